/* design/mfhp_pkg.sv */
package mfhp_pkg;

	localparam logic [31:0] SYNC_MASK  = 32'hffe0_0000;
	localparam logic [31:0] MATCH_MASK = 32'hfffe_0c00;

	// version and layer codes of the header
	localparam logic [1:0] VER_25  = 2'd0;
	localparam logic [1:0] VER_RSV = 2'd1;
	localparam logic [1:0] VER_2   = 2'd2;
	localparam logic [1:0] VER_1   = 2'd3;
	localparam logic [1:0] LAY_RSV = 2'd0;
	localparam logic [1:0] LAY_3   = 2'd1;
	localparam logic [1:0] LAY_2   = 2'd2;
	localparam logic [1:0] LAY_1   = 2'd3;

	localparam logic [3:0] BRI_FREE = 4'd0;
	localparam logic [3:0] BRI_BAD  = 4'd15;
	localparam logic [1:0] SRI_RSV  = 2'd3;
	localparam logic [1:0] MODE_MONO = 2'd3;

	localparam logic [10:0] SPF_L1   = 11'd384;
	localparam logic [10:0] SPF_HALF = 11'd576;
	localparam logic [10:0] SPF_FULL = 11'd1152;

	// frame length numerator and reciprocal of 147 for the 44.1 kHz family
	localparam int          NUM_W       = 20;
	localparam int          RECIP_W     = 19;
	localparam int          PROD_W      = NUM_W + RECIP_W;
	localparam int          RECIP_SHIFT = 26;
	localparam int          QUO_W       = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_147 = 19'd456523;

	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] RATE_BASE [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

	localparam logic [8:0] KBPS_L1_V1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
		9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam logic [8:0] KBPS_L1_V2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
		9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
	localparam logic [8:0] KBPS_L2_V1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
		9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam logic [8:0] KBPS_L3_V1 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
		9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam logic [8:0] KBPS_L23_V2 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
		9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	typedef enum logic [2:0] {
		TAB_L1_V1,
		TAB_L1_V2,
		TAB_L2_V1,
		TAB_L3_V1,
		TAB_L23_V2
	} kbps_tab_t;

	function automatic logic [8:0] kbps_lookup(kbps_tab_t tab, logic [3:0] bri);
		logic [8:0] k;
		unique case (tab)
			TAB_L1_V1:  k = KBPS_L1_V1[bri];
			TAB_L1_V2:  k = KBPS_L1_V2[bri];
			TAB_L2_V1:  k = KBPS_L2_V1[bri];
			TAB_L3_V1:  k = KBPS_L3_V1[bri];
			TAB_L23_V2: k = KBPS_L23_V2[bri];
			default:    k = '0;
		endcase
		return k;
	endfunction

	// classified header, as it waits in the queue
	typedef struct packed {
		logic              valid;
		logic              match;
		logic [NUM_W-1:0]  numer;
		logic              recip;
		logic [1:0]        shr;
		logic              pad;
		logic              quad;
		logic [15:0]       rate;
		logic [1:0]        chans;
		logic [8:0]        kbps;
		logic [10:0]       samples;
	} hdr_item_t;

	// result, header_valid in the lowest bit
	typedef struct packed {
		logic [10:0] samples_per_frame;
		logic [8:0]  bitrate_kbps;
		logic [1:0]  channel_count;
		logic [15:0] sample_rate_hz;
		logic [11:0] frame_bytes;
		logic        matches_reference;
		logic        header_valid;
	} result_t;

endpackage

/* design/mfhp_front.sv */
module mfhp_front import mfhp_pkg::*; (
	input  logic [31:0] header_word,
	input  logic [31:0] reference_header,
	output hdr_item_t   item
);

	logic [1:0]       ver;
	logic [1:0]       lay;
	logic [3:0]       bri;
	logic [1:0]       sri;
	logic             legal;
	logic [1:0]       vshift;
	logic             is_l1;
	logic             is_half;
	kbps_tab_t        tab;
	logic [8:0]       kbps;
	logic [8:0]       mul_a;
	logic             recip_sel;
	logic [1:0]       shr_sel;
	logic [NUM_W-1:0] prod_a;

	assign ver = header_word[20:19];
	assign lay = header_word[18:17];
	assign bri = header_word[15:12];
	assign sri = header_word[11:10];

	assign legal = ((header_word & SYNC_MASK) == SYNC_MASK) && (ver != VER_RSV) &&
		(lay != LAY_RSV) && (bri != BRI_FREE) && (bri != BRI_BAD) && (sri != SRI_RSV);

	assign is_l1   = (lay == LAY_1);
	assign is_half = (lay == LAY_3) && (ver != VER_1);

	always_comb begin
		unique case (ver)
			VER_1:   vshift = 2'd0;
			VER_2:   vshift = 2'd1;
			default: vshift = 2'd2;
		endcase
		if (is_l1) begin
			tab = (ver == VER_1) ? TAB_L1_V1 : TAB_L1_V2;
		end else if (ver == VER_1) begin
			tab = (lay == LAY_2) ? TAB_L2_V1 : TAB_L3_V1;
		end else begin
			tab = TAB_L23_V2;
		end
	end

	assign kbps = kbps_lookup(tab, bri);

	// frame bytes = mul_a * kbps * 2^vshift / divisor, divisor 147 or a power of two
	always_comb begin
		recip_sel = 1'b0;
		shr_sel   = 2'd0;
		mul_a     = 9'd0;
		unique case (sri)
			2'd0: begin
				recip_sel = 1'b1;
				mul_a     = is_l1 ? 9'd40 : (is_half ? 9'd240 : 9'd480);
			end
			2'd1: begin
				mul_a   = is_l1 ? 9'd1 : 9'd3;
				shr_sel = is_l1 ? 2'd2 : (is_half ? 2'd1 : 2'd0);
			end
			2'd2: begin
				mul_a   = is_l1 ? 9'd3 : 9'd9;
				shr_sel = is_l1 ? 2'd3 : (is_half ? 2'd2 : 2'd1);
			end
			default: begin
				mul_a = 9'd0;
			end
		endcase
	end

	assign prod_a = NUM_W'(mul_a) * NUM_W'(kbps);

	always_comb begin
		item.match = (reference_header == 32'd0) ||
			((header_word & MATCH_MASK) == (reference_header & MATCH_MASK));
		item.valid = legal;
		item.recip = recip_sel;
		item.shr   = shr_sel;
		if (legal) begin
			item.numer   = prod_a << vshift;
			item.pad     = header_word[9];
			item.quad    = is_l1;
			item.rate    = RATE_BASE[sri] >> vshift;
			item.chans   = (header_word[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
			item.kbps    = kbps;
			item.samples = is_l1 ? SPF_L1 : (is_half ? SPF_HALF : SPF_FULL);
		end else begin
			item.numer   = '0;
			item.pad     = 1'b0;
			item.quad    = 1'b0;
			item.rate    = '0;
			item.chans   = '0;
			item.kbps    = '0;
			item.samples = SPF_FULL;
		end
	end

endmodule

/* design/mfhp_queue.sv */
module mfhp_queue import mfhp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  hdr_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output hdr_item_t pop_item
);

	hdr_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

/* design/mfhp_back.sv */
module mfhp_back import mfhp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  hdr_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_result
);

	logic              valid_s1;
	hdr_item_t         item_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              valid_s2;
	result_t           result_s2;
	logic              adv_s1;
	logic              adv_s2;
	logic [QUO_W-1:0]  quo;
	logic [11:0]       slots;
	logic [11:0]       bytes;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// quotient: reciprocal product for 147, plain shift otherwise
	always_comb begin
		logic [NUM_W-1:0] shifted;
		shifted = item_s1.numer >> item_s1.shr;
		quo     = item_s1.recip ? prod_s1[PROD_W-1:RECIP_SHIFT] : shifted[QUO_W-1:0];
		slots   = 12'(quo) + 12'(item_s1.pad);
		bytes   = item_s1.quad ? {slots[9:0], 2'b00} : slots;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1 <= in_item;
			prod_s1 <= PROD_W'(in_item.numer) * PROD_W'(RECIP_147);
		end
		if (adv_s2 && valid_s1) begin
			result_s2.header_valid      <= item_s1.valid;
			result_s2.matches_reference <= item_s1.match;
			result_s2.frame_bytes       <= item_s1.valid ? bytes : 12'd0;
			result_s2.sample_rate_hz    <= item_s1.rate;
			result_s2.channel_count     <= item_s1.chans;
			result_s2.bitrate_kbps      <= item_s1.kbps;
			result_s2.samples_per_frame <= item_s1.samples;
		end
	end

	assign out_valid  = valid_s2;
	assign out_result = result_s2;

endmodule

/* design/mp3_frame_header_parser.sv */
// MPEG audio frame header decoder.
// Input stream: s_tdata carries one 32-bit candidate header, first stream byte
// in bits 31:24. Each transfer yields exactly one result on the output stream.
// Output stream: m_tdata carries validity, reference match, frame length,
// sample rate, channel count, bitrate and samples per frame.
// Configuration: cfg_data writes the reference header; cfg_ready is always high.
// Write it only while no header is in flight. Zero matches every header.
// Throughput: one header per cycle while m_tready is high. A classifier feeds
// a two-entry queue, then a two-stage back end (reciprocal multiply, then frame
// length). A header passes the queue, back-end stage one and the output register.
// When m_tready is low the output stage holds; the back end and the queue
// fill, and s_tready drops once the queue holds two headers.
// Reset: clears the queue, the pipeline valid bits and the reference header.
module mp3_frame_header_parser import mfhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,   // reference_header
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // header_word
	output logic        m_tvalid,
	input  logic        m_tready,
	// header_valid[0], matches_reference[1], frame_bytes[13:2], sample_rate_hz[29:14],
	// channel_count[31:30], bitrate_kbps[40:32], samples_per_frame[51:41], zeros above
	output logic [55:0] m_tdata
);

	logic [31:0] ref_q;
	hdr_item_t   front_item;
	logic        q_valid;
	logic        q_ready;
	hdr_item_t   q_item;
	result_t     result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			ref_q <= cfg_data;
		end
	end

	mfhp_front u_front (
		.header_word      (s_tdata),
		.reference_header (ref_q),
		.item             (front_item)
	);

	mfhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_tvalid),
		.push_ready (s_tready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	mfhp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_item    (q_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {4'b0000, result};

	// a transfer in always leaves something to pop
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> q_valid)
		else $error("queue empty after input transfer");

	// a full queue means the back end has work waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_valid)
		else $error("input stalled with empty queue");

	// invalid headers carry zeros and the default frame size
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !result.header_valid |->
			result.frame_bytes == 12'd0 && result.bitrate_kbps == 9'd0 &&
			result.channel_count == 2'd0 && result.samples_per_frame == SPF_FULL)
		else $error("invalid header with nonzero fields");

	// a legal header always has a nonzero length and channel count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result.header_valid |->
			result.frame_bytes != 12'd0 && result.channel_count != 2'd0)
		else $error("legal header with empty fields");

endmodule

/* tb/tb_mp3_frame_header_parser.sv */
`timescale 1ns / 1ps

module tb_mp3_frame_header_parser import mfhp_pkg::*;;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 116;
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int MAX_REPORTS     = 200;

	localparam int unsigned RATE_V1 [3] = '{44100, 48000, 32000};

	// rows follow kbps_tab_t, columns are bitrate index 1..14
	localparam int unsigned BITRATE_TAB [5][14] = '{
		'{32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
		'{32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
		'{32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
		'{32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320},
		'{8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
	};

	localparam result_t NO_HEADER = '{header_valid: 1'b0, matches_reference: 1'b1,
		samples_per_frame: SPF_FULL, default: '0};

	typedef struct packed {
		logic [31:0] header;
		logic        preset;
		result_t     want;
	} header_case_t;

	localparam int DIRECTED = 22;

	header_case_t directed_cases [DIRECTED] = '{
		'{32'h0000_0000, 1'b1, NO_HEADER},
		'{32'hFFFF_FFFF, 1'b1, NO_HEADER},
		'{32'hFFFB_9064, 1'b1, '{header_valid: 1'b1, matches_reference: 1'b1,
			frame_bytes: 12'd417, sample_rate_hz: 16'd44100, channel_count: 2'd2,
			bitrate_kbps: 9'd128, samples_per_frame: 11'd1152}},
		// longest frame: Layer II, V2.5 at 8 kHz, 160 kbit/s, padded
		'{32'hFFE5_EAC0, 1'b1, '{header_valid: 1'b1, matches_reference: 1'b1,
			frame_bytes: 12'd2881, sample_rate_hz: 16'd8000, channel_count: 2'd1,
			bitrate_kbps: 9'd160, samples_per_frame: 11'd1152}},
		'{32'hFFFE_E800, 1'b1, '{header_valid: 1'b1, matches_reference: 1'b1,
			frame_bytes: 12'd672, sample_rate_hz: 16'd32000, channel_count: 2'd2,
			bitrate_kbps: 9'd448, samples_per_frame: 11'd384}},
		'{32'hFFDB_9064, 1'b1, NO_HEADER},   // broken sync
		'{32'hFFEB_9064, 1'b1, NO_HEADER},   // reserved version
		'{32'hFFF9_9064, 1'b1, NO_HEADER},   // reserved layer
		'{32'hFFFB_0064, 1'b1, NO_HEADER},   // free bitrate
		'{32'hFFFB_9C64, 1'b1, NO_HEADER},   // reserved sample rate
		'{32'hFFFB_F064, 1'b1, NO_HEADER},   // bad bitrate
		'{32'hFFFD_16C0, 1'b0, '0},
		'{32'hFFF3_E244, 1'b0, '0},
		'{32'hFFE2_1800, 1'b0, '0},
		'{32'hFFF7_E4C0, 1'b0, '0},
		'{32'hFFE6_1A00, 1'b0, '0},
		'{32'hFFF5_7080, 1'b0, '0},
		'{32'hFFFF_1240, 1'b0, '0},
		'{32'hFFFB_EAFF, 1'b0, '0},
		'{32'hFFE5_9000, 1'b0, '0},
		'{32'hFFE0_0000, 1'b0, '0},
		'{32'h7FFF_FFFF, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;

	result_t     expected_results [$];
	logic [31:0] reference_copy;
	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned mismatches;
	int unsigned headers_sent;
	int unsigned legal_sent;
	int unsigned matched_sent;
	int unsigned reference_writes;

	mp3_frame_header_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic result_t decode_header(input logic [31:0] h, input logic [31:0] ref_hdr);
		result_t     r;
		logic [1:0]  ver;
		logic [1:0]  lay;
		logic [1:0]  sri;
		logic [3:0]  bri;
		kbps_tab_t   tab;
		int unsigned rate;
		int unsigned kbps;
		int unsigned bytes;
		ver = h[20:19];
		lay = h[18:17];
		bri = h[15:12];
		sri = h[11:10];
		r = '0;
		r.samples_per_frame = SPF_FULL;
		r.matches_reference = (ref_hdr == '0) || ((h & MATCH_MASK) == (ref_hdr & MATCH_MASK));
		if ((h & SYNC_MASK) == SYNC_MASK && ver != VER_RSV && lay != LAY_RSV &&
				bri != BRI_FREE && bri != BRI_BAD && sri != SRI_RSV) begin
			rate = RATE_V1[sri];
			if (ver == VER_2)
				rate = rate / 2;
			else if (ver == VER_25)
				rate = rate / 4;
			if (lay == LAY_1)
				tab = (ver == VER_1) ? TAB_L1_V1 : TAB_L1_V2;
			else if (ver == VER_1)
				tab = (lay == LAY_2) ? TAB_L2_V1 : TAB_L3_V1;
			else
				tab = TAB_L23_V2;
			kbps = BITRATE_TAB[tab][bri - 1];
			if (lay == LAY_1) begin
				bytes = (12000 * kbps / rate + h[9]) * 4;
				r.samples_per_frame = SPF_L1;
			end else if (lay == LAY_3 && ver != VER_1) begin
				bytes = 72000 * kbps / rate + h[9];
				r.samples_per_frame = SPF_HALF;
			end else begin
				bytes = 144000 * kbps / rate + h[9];
			end
			r.header_valid   = 1'b1;
			r.frame_bytes    = bytes[11:0];
			r.sample_rate_hz = rate[15:0];
			r.bitrate_kbps   = kbps[8:0];
			r.channel_count  = (h[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
		end
		return r;
	endfunction

	// mostly well-formed headers; part copies the masked fields of the reference
	function automatic logic [31:0] random_header(input logic [31:0] ref_hdr);
		logic [31:0] h;
		int unsigned pick;
		h = $urandom;
		pick = $urandom_range(99);
		if (pick < 15)
			return h;
		h = h | SYNC_MASK;
		if (ref_hdr != '0 && pick < 45) begin
			h = (ref_hdr & MATCH_MASK) | (h & ~MATCH_MASK);
		end else if (pick < 90) begin
			case ($urandom_range(2))
				0: h[20:19] = VER_25;
				1: h[20:19] = VER_2;
				default: h[20:19] = VER_1;
			endcase
			h[18:17] = 2'($urandom_range(3, 1));
			h[15:12] = 4'($urandom_range(14, 1));
			h[11:10] = 2'($urandom_range(2));
		end
		return h;
	endfunction

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s", $time, what);
		else if (mismatches == MAX_REPORTS + 1)
			$display("%0t: further mismatches not shown", $time);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got)
			report($sformatf("%s expected %0d, actual %0d", name, want, got));
	endtask

	task automatic send_header(input logic [31:0] h, input result_t want);
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= h;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(want);
		headers_sent++;
		if (want.header_valid)
			legal_sent++;
		if (want.matches_reference)
			matched_sent++;
	endtask

	task automatic write_reference(input logic [31:0] value);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		reference_copy = value;
		reference_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk)
		m_tready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[51:0]);
			if (expected_results.size() == 0) begin
				report($sformatf("result with no header in flight: expected none, actual %h",
					m_tdata));
			end else begin
				want = expected_results.pop_front();
				check_field("header_valid", want.header_valid, got.header_valid);
				check_field("matches_reference", want.matches_reference, got.matches_reference);
				check_field("frame_bytes", want.frame_bytes, got.frame_bytes);
				check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
				check_field("channel_count", want.channel_count, got.channel_count);
				check_field("bitrate_kbps", want.bitrate_kbps, got.bitrate_kbps);
				check_field("samples_per_frame", want.samples_per_frame, got.samples_per_frame);
				check_field("m_tdata padding", 0, m_tdata[55:52]);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		do begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end while (quiet < WATCHDOG_LIMIT);
		$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time, quiet,
			expected_results.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] h;
		logic [31:0] phase_ref;
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_data         = '0;
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		m_tready         = 1'b0;
		src_idle_pct     = 0;
		sink_idle_pct    = 0;
		reference_copy   = '0;
		mismatches       = 0;
		headers_sent     = 0;
		legal_sent       = 0;
		matched_sent     = 0;
		reference_writes = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_cases[i])
			send_header(directed_cases[i].header, directed_cases[i].preset ?
				directed_cases[i].want : decode_header(directed_cases[i].header, reference_copy));

		for (int p = 0; p < PHASES; p++) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			case (p)
				0: phase_ref = 32'hFFFB_9064;
				1: phase_ref = 32'hFFFF_FFFF;
				2: phase_ref = 32'h0000_0000;
				3: phase_ref = random_header(32'h0);
				4: phase_ref = MATCH_MASK;
				5: phase_ref = $urandom;
				6: phase_ref = 32'hFFE5_EAC0;
				default: phase_ref = 32'h0000_0001;
			endcase
			write_reference(phase_ref);
			case (p % 4)
				0: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
				1: begin
					src_idle_pct  = 68;
					sink_idle_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					sink_idle_pct = 68;
				end
				default: begin
					src_idle_pct  = 35;
					sink_idle_pct = 35;
				end
			endcase
			repeat (ITEMS_PER_PHASE) begin
				h = random_header(reference_copy);
				send_header(h, decode_header(h, reference_copy));
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Decoded %0d headers (%0d legal, %0d matching the reference) under %0d references",
			headers_sent, legal_sent, matched_sent, reference_writes + 1);
		$display("Flow control ran free, with source gaps, with sink stalls and with both");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
